// ----- hdl/rhc_pkg.sv -----
// Shared constants, types and widths for the RGB to HSV converter.
package rhc_pkg;

  // Channel and result formats
  localparam int CHAN_W        = 8;
  localparam int COLOR_W       = 3 * CHAN_W;
  localparam int HUE_FRAC_BITS = 6;
  localparam int SAT_FRAC_BITS = 12;
  localparam int HUE_W         = HUE_FRAC_BITS + 9;
  localparam int SAT_W         = SAT_FRAC_BITS + 1;

  // mag*60 fits in 14 bits for an 8-bit magnitude
  localparam int MAG60_W = CHAN_W + 6;

  // Divider sizing: quotient bits, dividend bits and working width
  localparam int HUE_Q_W = HUE_FRAC_BITS + 6;
  localparam int SAT_Q_W = SAT_FRAC_BITS + 1;
  localparam int DIV_Q_W = (HUE_Q_W > SAT_Q_W) ? HUE_Q_W : SAT_Q_W;
  localparam int HUE_N_W = MAG60_W + HUE_FRAC_BITS;
  localparam int SAT_N_W = CHAN_W + SAT_FRAC_BITS;
  localparam int DIV_N_W = (HUE_N_W > SAT_N_W) ? HUE_N_W : SAT_N_W;
  localparam int DIV_W   = (DIV_N_W > CHAN_W + DIV_Q_W) ? DIV_N_W : CHAN_W + DIV_Q_W;

  // Transfer to result: input reg, channel stats reg, divider stages, output reg
  localparam int PIPE_LAT = DIV_Q_W + 3;

  // Hue sector offsets and full turn, scaled to the hue format
  localparam logic [HUE_W-1:0] HUE_120 = HUE_W'(120 * (1 << HUE_FRAC_BITS));
  localparam logic [HUE_W-1:0] HUE_240 = HUE_W'(240 * (1 << HUE_FRAC_BITS));
  localparam logic [HUE_W-1:0] HUE_360 = HUE_W'(360 * (1 << HUE_FRAC_BITS));
  localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(1 << SAT_FRAC_BITS);

  // Which channel holds the maximum
  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Data that rides alongside the dividers
  typedef struct packed {
    logic              neg;
    sector_t           sect;
    logic [CHAN_W-1:0] bright;
  } rhc_side_t;

endpackage

// ----- hdl/rgb_to_hsv_converter_core.sv -----
// RGB to HSV converter: top level with channel stats, dividers and hue assembly.
//
// Converts one packed 24-bit colour (red bits 7:0, green 15:8, blue 23:16) into
// hue (degrees, 6 fractional bits), saturation (12 fractional bits, 4096 = 1.0)
// and brightness (the largest channel). A colour is taken on every clock edge
// where start is high and busy is low; busy is high only while rst_n is low, so
// one colour can be transferred every cycle. Each result appears on the out_
// ports for a single cycle, flagged by out_valid, and results come out in input
// order. A colour passes through one input register, one channel-statistics
// register, the two 13-stage restoring dividers (one quotient bit per stage) and
// one output register. Black gives zero hue and saturation; grey gives zero hue.
// On a tie for the maximum, red wins over green and green over blue.
module rgb_to_hsv_converter_core
  import rhc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [COLOR_W-1:0] in_packed_color,
  output logic               out_valid,
  output logic [HUE_W-1:0]   out_hue,
  output logic [SAT_W-1:0]   out_saturation,
  output logic [CHAN_W-1:0]  out_brightness
);

  // Input register
  logic               v1_r;
  logic [COLOR_W-1:0] col1_r;

  // Channel statistics stage
  logic [CHAN_W-1:0] r1, g1, b1;
  logic [CHAN_W-1:0] mx_nxt, mn_nxt;
  logic              v2_r;
  logic [CHAN_W-1:0] r2_r, g2_r, b2_r, mx2_r, mn2_r;

  // Divider set-up
  logic [CHAN_W-1:0]  delta;
  logic [CHAN_W-1:0]  mag;
  logic [MAG60_W-1:0] mag60;
  logic [DIV_W-1:0]   hue_num, sat_num;
  logic [CHAN_W-1:0]  hue_den, sat_den;
  rhc_side_t          side_nxt;

  // Sideband delay line matched to divider latency
  logic      vd_r   [DIV_Q_W];
  rhc_side_t side_r [DIV_Q_W];

  logic [DIV_Q_W-1:0] hue_q, sat_q;

  // Output assembly
  rhc_side_t        side_last;
  logic [HUE_W-1:0] hue_qx;
  logic [HUE_W-1:0] hue_nxt;
  logic             out_valid_r;
  logic [HUE_W-1:0]  out_hue_r;
  logic [SAT_W-1:0]  out_sat_r;
  logic [CHAN_W-1:0] out_bright_r;

  assign busy = ~rst_n;

  // Control: valid bits along the pipe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < DIV_Q_W; i++) vd_r[i] <= 1'b0;
    end else begin
      v1_r        <= start && !busy;
      v2_r        <= v1_r;
      vd_r[0]     <= v2_r;
      for (int i = 1; i < DIV_Q_W; i++) vd_r[i] <= vd_r[i-1];
      out_valid_r <= vd_r[DIV_Q_W-1];
    end
  end

  // Max and min of the three channels
  always_comb begin
    r1     = col1_r[CHAN_W-1:0];
    g1     = col1_r[2*CHAN_W-1:CHAN_W];
    b1     = col1_r[3*CHAN_W-1:2*CHAN_W];
    mx_nxt = r1;
    mn_nxt = r1;
    if (g1 > mx_nxt) mx_nxt = g1;
    if (b1 > mx_nxt) mx_nxt = b1;
    if (g1 < mn_nxt) mn_nxt = g1;
    if (b1 < mn_nxt) mn_nxt = b1;
  end

  // Sector choice, signed difference and divider operands
  always_comb begin
    delta = mx2_r - mn2_r;
    priority if (r2_r == mx2_r) begin
      side_nxt.sect = SECT_RED;
      side_nxt.neg  = (g2_r < b2_r);
      mag           = side_nxt.neg ? (b2_r - g2_r) : (g2_r - b2_r);
    end else if (g2_r == mx2_r) begin
      side_nxt.sect = SECT_GREEN;
      side_nxt.neg  = (b2_r < r2_r);
      mag           = side_nxt.neg ? (r2_r - b2_r) : (b2_r - r2_r);
    end else begin
      side_nxt.sect = SECT_BLUE;
      side_nxt.neg  = (r2_r < g2_r);
      mag           = side_nxt.neg ? (g2_r - r2_r) : (r2_r - g2_r);
    end
    side_nxt.bright = mx2_r;
    // mag*60 as mag*64 - mag*4
    mag60   = (MAG60_W'(mag) << 6) - (MAG60_W'(mag) << 2);
    hue_num = DIV_W'(mag60) << HUE_FRAC_BITS;
    sat_num = DIV_W'(delta) << SAT_FRAC_BITS;
    // Zero divisors only occur with zero dividends; use one to keep quotient zero
    hue_den = (delta == '0) ? CHAN_W'(1) : delta;
    sat_den = (mx2_r == '0) ? CHAN_W'(1) : mx2_r;
  end

  // Payload registers
  always_ff @(posedge clk) begin
    col1_r    <= in_packed_color;
    r2_r      <= r1;
    g2_r      <= g1;
    b2_r      <= b1;
    mx2_r     <= mx_nxt;
    mn2_r     <= mn_nxt;
    side_r[0] <= side_nxt;
    for (int i = 1; i < DIV_Q_W; i++) side_r[i] <= side_r[i-1];
    out_hue_r    <= hue_nxt;
    out_sat_r    <= SAT_W'(sat_q);
    out_bright_r <= side_last.bright;
  end

  rhc_div u_hue_div (
    .clk      (clk),
    .dividend (hue_num),
    .divisor  (hue_den),
    .quotient (hue_q)
  );

  rhc_div u_sat_div (
    .clk      (clk),
    .dividend (sat_num),
    .divisor  (sat_den),
    .quotient (sat_q)
  );

  // Hue: sector offset plus or minus quotient, wrapped into one turn
  always_comb begin
    side_last = side_r[DIV_Q_W-1];
    hue_qx    = HUE_W'(hue_q);
    unique case (side_last.sect)
      SECT_RED:   hue_nxt = side_last.neg ? (HUE_360 - hue_qx) : hue_qx;
      SECT_GREEN: hue_nxt = side_last.neg ? (HUE_120 - hue_qx) : (HUE_120 + hue_qx);
      SECT_BLUE:  hue_nxt = side_last.neg ? (HUE_240 - hue_qx) : (HUE_240 + hue_qx);
      default:    hue_nxt = '0;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = out_hue_r;
  assign out_saturation = out_sat_r;
  assign out_brightness = out_bright_r;

`ifndef ASSERT_OFF
  // Every transfer gives exactly one result
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LAT out_valid)
    else $error("result missing after input transfer");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PIPE_LAT))
    else $error("result without matching input transfer");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hue < HUE_360))
    else $error("hue outside one turn");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_saturation <= SAT_ONE))
    else $error("saturation above one");

  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_brightness == '0) |-> (out_hue == '0 && out_saturation == '0))
    else $error("black gives nonzero hue or saturation");
`endif

endmodule

// ----- hdl/rhc_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
module rhc_div
  import rhc_pkg::*;
(
  input  logic               clk,
  input  logic [DIV_W-1:0]   dividend,
  input  logic [CHAN_W-1:0]  divisor,
  output logic [DIV_Q_W-1:0] quotient
);

  logic [DIV_W-1:0]   rem_r [DIV_Q_W];
  logic [CHAN_W-1:0]  den_r [DIV_Q_W];
  logic [DIV_Q_W-1:0] quo_r [DIV_Q_W];

  // Stage k resolves quotient bit DIV_Q_W-1-k
  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    logic [DIV_W-1:0]   rem_in;
    logic [CHAN_W-1:0]  den_in;
    logic [DIV_Q_W-1:0] quo_in;
    logic [DIV_W-1:0]   shifted;
    logic               fits;
    logic [DIV_W-1:0]   rem_nxt;
    logic [DIV_Q_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign rem_in = dividend;
      assign den_in = divisor;
      assign quo_in = '0;
    end else begin : g_rest
      assign rem_in = rem_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    always_comb begin
      shifted = DIV_W'(den_in) << (DIV_Q_W - 1 - k);
      fits    = (rem_in >= shifted);
      rem_nxt = fits ? (rem_in - shifted) : rem_in;
      quo_nxt = quo_in;
      quo_nxt[DIV_Q_W-1-k] = fits;
    end

    always_ff @(posedge clk) begin
      rem_r[k] <= rem_nxt;
      den_r[k] <= den_in;
      quo_r[k] <= quo_nxt;
    end
  end

  assign quotient = quo_r[DIV_Q_W-1];

endmodule
